// ----- src/pde_pkg.sv -----
// ----------------------------------------------------------------------------
// pde_pkg: shared types and constants
// Phase codes, opcode codes, mode codes, fault codes and the request/result payloads.
// ----------------------------------------------------------------------------
package pde_pkg;

  localparam int unsigned BLOCK_DEPTH_DEF = 256;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ARG    = 4'd1,
    PH_V2     = 4'd2,
    PH_V3     = 4'd3,
    PH_LOAD   = 4'd4,
    PH_ZERO   = 4'd5,
    PH_REPLAY = 4'd6,
    PH_CUSTOM = 4'd7
  } phase_t;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_PULL    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [2:0] MD_ZERO   = 3'd0;
  localparam logic [2:0] MD_COPY   = 3'd1;
  localparam logic [2:0] MD_REPEAT = 3'd2;
  localparam logic [2:0] MD_ILV    = 3'd3;
  localparam logic [2:0] MD_ZILV   = 3'd4;
  localparam logic [2:0] MD_RSV5   = 3'd5;
  localparam logic [2:0] MD_RSV6   = 3'd6;
  localparam logic [2:0] MD_RSV7   = 3'd7;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_UNDEF = 2'd1;
  localparam logic [1:0] FLT_BIG   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] packed_byte;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       piece_end;
    logic       at_boundary;
    logic [1:0] fault;
  } res_t;

endpackage

// ----- src/pde_if.sv -----
// ----------------------------------------------------------------------------
// pde_req_if / pde_res_if: valid/ready channels
// Request and result channels of the expander.
// ----------------------------------------------------------------------------
interface pde_req_if;
  logic          valid;
  logic          ready;
  pde_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pde_res_if;
  logic          valid;
  logic          ready;
  pde_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/pde_store.sv -----
// ----------------------------------------------------------------------------
// pde_store: common block buffer
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module pde_store #(
  parameter int unsigned DEPTH = pde_pkg::BLOCK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/pde_core.sv -----
// ----------------------------------------------------------------------------
// pde_core: instruction decoder and sequencer
// Steps one request per cycle while step is high and writes the result into an
// output register. Replay bytes are prefetched from the buffer at the index of the
// next state, so the byte at the current replay index is always ready in rd_data.
// ----------------------------------------------------------------------------
module pde_core #(
  parameter int unsigned DEPTH = pde_pkg::BLOCK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  pde_pkg::req_t req,
  output pde_pkg::res_t res,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data
);

  localparam logic [31:0] DEPTH32 = 32'(DEPTH);
  localparam logic [AW:0] DEPTH_I = (AW+1)'(DEPTH);

  pde_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] vacc_r, vacc_nxt;
  logic [31:0] blen_r, blen_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [31:0] ccnt_r, ccnt_nxt;
  logic [31:0] rep_r, rep_nxt;
  logic [31:0] left_r, left_nxt;
  logic [AW:0] bidx_r, bidx_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        full_r, full_nxt;
  pde_pkg::res_t res_nxt;

  // Sequencing after a piece ends; done=1 when the instruction is complete.
  // Loop iterations are bounded at four and act on a handful of flags.
  function automatic void seq_fn(
    input  logic [0:0]  kind_in,
    input  logic [2:0]  md,
    input  logic [31:0] blen, input logic [31:0] clen,
    inout  logic [31:0] ccnt, inout logic [31:0] rep,
    inout  pde_pkg::phase_t ph, inout logic [31:0] left,
    inout  logic [AW:0] bidx, output logic done);
    logic kind;
    logic fin;
    kind = kind_in[0];
    fin  = 1'b0;
    done = 1'b0;
    for (int g = 0; g < 4; g++) begin
      if (!fin) begin
        if (!kind) begin
          if (md == pde_pkg::MD_REPEAT) begin
            if (rep == 32'd0 || blen == 32'd0) begin
              ph = pde_pkg::PH_IDLE; left = 32'd0; done = 1'b1;
            end else begin
              rep = rep - 32'd1; bidx = '0; left = blen; ph = pde_pkg::PH_REPLAY;
            end
            fin = 1'b1;
          end else if (md == pde_pkg::MD_ILV || md == pde_pkg::MD_ZILV) begin
            if (ccnt == 32'd0) begin
              ph = pde_pkg::PH_IDLE; left = 32'd0; done = 1'b1; fin = 1'b1;
            end else begin
              ccnt = ccnt - 32'd1;
              if (clen == 32'd0) begin
                kind = 1'b1;
              end else begin
                left = clen; ph = pde_pkg::PH_CUSTOM; fin = 1'b1;
              end
            end
          end else begin
            ph = pde_pkg::PH_IDLE; left = 32'd0; done = 1'b1; fin = 1'b1;
          end
        end else begin
          if (blen == 32'd0) begin
            kind = 1'b0;
          end else if (md == pde_pkg::MD_ILV) begin
            bidx = '0; left = blen; ph = pde_pkg::PH_REPLAY; fin = 1'b1;
          end else if (md == pde_pkg::MD_ZILV) begin
            left = blen; ph = pde_pkg::PH_ZERO; fin = 1'b1;
          end else begin
            ph = pde_pkg::PH_IDLE; left = 32'd0; done = 1'b1; fin = 1'b1;
          end
        end
      end
    end
    if (!fin) begin
      ph = pde_pkg::PH_IDLE; left = 32'd0; done = 1'b1;
    end
  endfunction

  // Next state and result of one request.
  always_comb begin
    logic [31:0] v;
    logic [31:0] a;
    logic        dn;
    logic [1:0]  flt;
    phase_nxt = phase_r; mode_nxt = mode_r; vacc_nxt = vacc_r;
    blen_nxt = blen_r; clen_nxt = clen_r; ccnt_nxt = ccnt_r; rep_nxt = rep_r;
    left_nxt = left_r; bidx_nxt = bidx_r; hold_nxt = hold_r; full_nxt = full_r;
    wr_en = 1'b0; wr_addr = bidx_r[AW-1:0]; wr_data = req.packed_byte;
    flt = pde_pkg::FLT_NONE; dn = 1'b0;
    v = 32'd0; a = 32'd0;
    res_nxt = '0;
    case (req.op)
      pde_pkg::OP_PUSH: begin
        if (!full_r) begin
          res_nxt.accepted = 1'b1;
          v = {vacc_r[24:0], req.packed_byte[6:0]};
          a = 32'd0;
          if (phase_r == pde_pkg::PH_IDLE) begin
            mode_nxt = req.packed_byte[7:5];
            a = {27'd0, req.packed_byte[4:0]};
          end
          case (phase_r)
            pde_pkg::PH_IDLE, pde_pkg::PH_ARG, pde_pkg::PH_V2, pde_pkg::PH_V3: begin
              if (phase_r != pde_pkg::PH_IDLE) vacc_nxt = v;
              if (phase_r == pde_pkg::PH_IDLE && a == 32'd0) begin
                vacc_nxt = 32'd0; phase_nxt = pde_pkg::PH_ARG;
              end else if (phase_r == pde_pkg::PH_IDLE || !req.packed_byte[7]) begin
                if (phase_r != pde_pkg::PH_IDLE) a = v;
                if (phase_r == pde_pkg::PH_IDLE || phase_r == pde_pkg::PH_ARG) begin
                  // Argument known: start the instruction.
                  blen_nxt = a; left_nxt = a;
                  if (mode_nxt == pde_pkg::MD_ZERO) begin
                    phase_nxt = (a == 32'd0) ? pde_pkg::PH_IDLE : pde_pkg::PH_ZERO;
                    if (a == 32'd0) left_nxt = 32'd0;
                  end else if (mode_nxt == pde_pkg::MD_COPY) begin
                    phase_nxt = (a == 32'd0) ? pde_pkg::PH_IDLE : pde_pkg::PH_LOAD;
                    if (a == 32'd0) left_nxt = 32'd0;
                  end else if (mode_nxt <= pde_pkg::MD_ZILV) begin
                    vacc_nxt = 32'd0; phase_nxt = pde_pkg::PH_V2;
                  end else begin
                    flt = pde_pkg::FLT_UNDEF;
                    phase_nxt = pde_pkg::PH_IDLE; left_nxt = 32'd0;
                  end
                end else if (phase_r == pde_pkg::PH_V2 && mode_r != pde_pkg::MD_REPEAT) begin
                  clen_nxt = a; vacc_nxt = 32'd0; phase_nxt = pde_pkg::PH_V3;
                end else begin
                  if (phase_r == pde_pkg::PH_V2) rep_nxt = a;
                  else ccnt_nxt = a;
                  if (phase_r == pde_pkg::PH_V3 && clen_r == 32'd0 && blen_r == 32'd0) begin
                    phase_nxt = pde_pkg::PH_IDLE; left_nxt = 32'd0;
                  end else if (phase_r == pde_pkg::PH_V2 || mode_r == pde_pkg::MD_ILV) begin
                    // Common block load.
                    if (blen_r > DEPTH32) begin
                      flt = pde_pkg::FLT_BIG; blen_nxt = DEPTH32;
                    end
                    bidx_nxt = '0; left_nxt = blen_r;
                    if (blen_r == 32'd0) begin
                      if (mode_r == pde_pkg::MD_REPEAT) begin
                        phase_nxt = pde_pkg::PH_IDLE; left_nxt = 32'd0;
                      end else begin
                        seq_fn(1'b0, mode_r, blen_nxt, clen_nxt, ccnt_nxt, rep_nxt,
                               phase_nxt, left_nxt, bidx_nxt, dn);
                      end
                    end else begin
                      phase_nxt = pde_pkg::PH_LOAD;
                    end
                  end else if (blen_r == 32'd0) begin
                    seq_fn(1'b0, mode_r, blen_r, clen_nxt, ccnt_nxt, rep_nxt,
                           phase_nxt, left_nxt, bidx_nxt, dn);
                  end else begin
                    left_nxt = blen_r; phase_nxt = pde_pkg::PH_ZERO;
                  end
                end
              end
            end
            pde_pkg::PH_LOAD: begin
              left_nxt = left_r - 32'd1;
              if (mode_r == pde_pkg::MD_COPY) begin
                hold_nxt = req.packed_byte; full_nxt = 1'b1;
              end else if ({{(31-AW){1'b0}}, bidx_r} < blen_r && bidx_r < DEPTH_I) begin
                wr_en = step;
                bidx_nxt = bidx_r + 1'b1;
                hold_nxt = req.packed_byte; full_nxt = 1'b1;
              end else if (left_nxt == 32'd0) begin
                seq_fn(1'b0, mode_r, blen_r, clen_r, ccnt_nxt, rep_nxt,
                       phase_nxt, left_nxt, bidx_nxt, dn);
              end
            end
            pde_pkg::PH_CUSTOM: begin
              left_nxt = left_r - 32'd1;
              hold_nxt = req.packed_byte; full_nxt = 1'b1;
            end
            default: res_nxt.accepted = 1'b0;
          endcase
        end
      end
      pde_pkg::OP_PULL: begin
        if (full_r) begin
          res_nxt.out_valid = 1'b1; res_nxt.out_byte = hold_r;
          full_nxt = 1'b0; hold_nxt = 8'd0;
          if (left_r == 32'd0 &&
              (phase_r == pde_pkg::PH_LOAD || phase_r == pde_pkg::PH_CUSTOM)) begin
            seq_fn(phase_r == pde_pkg::PH_CUSTOM, mode_r, blen_r, clen_r, ccnt_nxt,
                   rep_nxt, phase_nxt, left_nxt, bidx_nxt, dn);
            res_nxt.piece_end = dn;
          end
        end else if ((phase_r == pde_pkg::PH_ZERO || phase_r == pde_pkg::PH_REPLAY)
                     && left_r != 32'd0) begin
          res_nxt.out_valid = 1'b1;
          if (phase_r == pde_pkg::PH_REPLAY) begin
            res_nxt.out_byte = (bidx_r < DEPTH_I) ? rd_data : 8'd0;
            bidx_nxt = bidx_r + 1'b1;
          end
          left_nxt = left_r - 32'd1;
          if (left_nxt == 32'd0) begin
            seq_fn(1'b0, mode_r, blen_r, clen_r, ccnt_nxt, rep_nxt,
                   phase_nxt, left_nxt, bidx_nxt, dn);
            res_nxt.piece_end = dn;
          end
        end
      end
      pde_pkg::OP_RESTART: begin
        phase_nxt = pde_pkg::PH_IDLE; mode_nxt = pde_pkg::MD_ZERO; vacc_nxt = 32'd0;
        blen_nxt = 32'd0; clen_nxt = 32'd0; ccnt_nxt = 32'd0; rep_nxt = 32'd0;
        left_nxt = 32'd0; bidx_nxt = '0; hold_nxt = 8'd0; full_nxt = 1'b0;
      end
      default: ;
    endcase
    res_nxt.at_boundary = (phase_nxt == pde_pkg::PH_IDLE) && !full_nxt;
    res_nxt.fault = flt;
  end

  // Prefetch the byte at the next replay index. A write always goes to the
  // current load index, never to the entry being prefetched.
  assign rd_en   = step;
  assign rd_addr = bidx_nxt[AW-1:0];

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pde_pkg::PH_IDLE; mode_r <= pde_pkg::MD_ZERO; vacc_r <= 32'd0;
      blen_r <= 32'd0; clen_r <= 32'd0; ccnt_r <= 32'd0; rep_r <= 32'd0;
      left_r <= 32'd0; bidx_r <= '0; hold_r <= 8'd0; full_r <= 1'b0;
      res <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; mode_r <= mode_nxt; vacc_r <= vacc_nxt;
      blen_r <= blen_nxt; clen_r <= clen_nxt; ccnt_r <= ccnt_nxt; rep_r <= rep_nxt;
      left_r <= left_nxt; bidx_r <= bidx_nxt; hold_r <= hold_nxt; full_r <= full_nxt;
      res <= res_nxt;
    end
  end

endmodule

// ----- src/pattern_data_expander_unit.sv -----
// ----------------------------------------------------------------------------
// pattern_data_expander_unit: pattern-initialized data expander
// Top level: request channel, decoder core, common block buffer, result reg.
// ----------------------------------------------------------------------------
// Usage: each request carries op (push packed byte, pull expanded byte,
// restart, no-op) and packed_byte. Every request yields exactly one result with
// accepted, out_valid, out_byte, piece_end, at_boundary and fault.
// Each result is registered and offered in the cycle after its request. Throughput
// is one request per cycle: the core steps whenever the result register is empty
// or is being taken in the same cycle, so a stalled receiver holds the result and
// stops the request channel only while that register is full.
// Replay bytes come from the block buffer, whose single read port is
// addressed one request ahead, so a replayed byte is ready without waiting on the read.
// A buffer write never targets the entry that is prefetched in that cycle.
// Reset clears all counters and the result register; the buffer contents
// are left as they are and are only read after being written.
// ----------------------------------------------------------------------------
module pattern_data_expander_unit #(
  parameter int unsigned BLOCK_DEPTH = pde_pkg::BLOCK_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  pde_req_if.sink  in_ch,
  pde_res_if.source out_ch
);

  localparam int unsigned AW = $clog2(BLOCK_DEPTH);

  logic          res_full_r;
  logic          step;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // A request steps the core when the result slot is free or is being emptied.
  assign in_ch.ready  = !res_full_r || out_ch.ready;
  assign step         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = res_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_full_r <= 1'b0;
    end else if (step) begin
      res_full_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_full_r <= 1'b0;
    end
  end

  pde_core #(.DEPTH(BLOCK_DEPTH)) u_core (
    .clk, .rst_n, .step, .req(in_ch.data), .res(out_ch.data),
    .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data
  );

  pde_store #(.DEPTH(BLOCK_DEPTH)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data
  );

endmodule

// ----- src/pde_checker.sv -----
// ----------------------------------------------------------------------------
// pde_checker: port-level checks
// Result register handshake and result field consistency.
// ----------------------------------------------------------------------------
module pde_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input pde_pkg::res_t out_data
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Requests are taken whenever the result slot is free.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty result slot");

  // A request gives a result next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("missing result");

  // A pushed and a pulled byte never share one result; piece_end needs out_valid.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.accepted && out_data.out_valid) &&
                  !(out_data.piece_end && !out_data.out_valid))
    else $error("inconsistent result fields");

endmodule

bind pattern_data_expander_unit pde_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for pattern_data_expander_unit
// Builds a request stream of packed instructions, pulls, restarts and no-ops, and
// predicts each result with an internal copy of the decoder. A clocked driver
// sends the requests and a clocked monitor compares every result with the
// oldest prediction, with random idling on both channels over the first two thirds.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = pde_pkg::BLOCK_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;

  pde_req_if req_ch ();
  pde_res_if res_ch ();

  pattern_data_expander_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Decoder state mirrored by the predictor.
  pde_pkg::phase_t ph;
  logic [2:0]  md;
  int unsigned vacc, blen, clen, ccount, rleft, pleft, bidx;
  logic [7:0]  hold_b;
  bit          hold_f;
  logic [7:0]  block_mem [DEPTH];
  logic [1:0]  flt;

  pde_pkg::req_t pending_reqs [$];
  pde_pkg::res_t expected_results [$];
  int          total_reqs;
  int          sent_reqs;
  int          errors;
  int unsigned cycles;
  bit          gen_done;

  // Clock and reset.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit end_instr();
    ph = pde_pkg::PH_IDLE;
    pleft = 0;
    return 1'b1;
  endfunction

  function automatic void begin_replay();
    bidx = 0;
    pleft = blen;
    ph = pde_pkg::PH_REPLAY;
  endfunction

  // Advances to the next piece; kind 0 after a common piece, 1 after custom.
  function automatic bit next_piece(int kind);
    for (int guard = 0; guard < 4; guard++) begin
      if (kind == 0) begin
        if (md == pde_pkg::MD_REPEAT) begin
          if (rleft == 0 || blen == 0) return end_instr();
          rleft--;
          begin_replay();
          return 1'b0;
        end
        if (md == pde_pkg::MD_ILV || md == pde_pkg::MD_ZILV) begin
          if (ccount == 0) return end_instr();
          ccount--;
          if (clen == 0) begin
            kind = 1;
            continue;
          end
          pleft = clen;
          ph = pde_pkg::PH_CUSTOM;
          return 1'b0;
        end
        return end_instr();
      end
      if (blen == 0) begin
        kind = 0;
        continue;
      end
      if (md == pde_pkg::MD_ILV) begin
        begin_replay();
        return 1'b0;
      end
      if (md == pde_pkg::MD_ZILV) begin
        pleft = blen;
        ph = pde_pkg::PH_ZERO;
        return 1'b0;
      end
      return end_instr();
    end
    return end_instr();
  endfunction

  function automatic void begin_load();
    int unsigned full;
    full = blen;
    if (full > DEPTH) begin
      flt = pde_pkg::FLT_BIG;
      blen = DEPTH;
    end
    bidx = 0;
    pleft = full;
    if (full == 0) begin
      if (md == pde_pkg::MD_REPEAT) void'(end_instr());
      else void'(next_piece(0));
      return;
    end
    ph = pde_pkg::PH_LOAD;
  endfunction

  function automatic void begin_arg(int unsigned a);
    blen = a;
    pleft = a;
    if (md == pde_pkg::MD_ZERO) begin
      if (a == 0) void'(end_instr()); else ph = pde_pkg::PH_ZERO;
    end else if (md == pde_pkg::MD_COPY) begin
      if (a == 0) void'(end_instr()); else ph = pde_pkg::PH_LOAD;
    end else if (md <= pde_pkg::MD_ZILV) begin
      vacc = 0;
      ph = pde_pkg::PH_V2;
    end else begin
      flt = pde_pkg::FLT_UNDEF;
      void'(end_instr());
    end
  endfunction

  function automatic void varint_complete(int unsigned v);
    if (ph == pde_pkg::PH_ARG) begin
      begin_arg(v);
    end else if (ph == pde_pkg::PH_V2) begin
      if (md == pde_pkg::MD_REPEAT) begin
        rleft = v;
        begin_load();
      end else begin
        clen = v;
        vacc = 0;
        ph = pde_pkg::PH_V3;
      end
    end else begin
      ccount = v;
      if (clen == 0 && blen == 0) void'(end_instr());
      else if (md == pde_pkg::MD_ILV) begin_load();
      else if (blen == 0) void'(next_piece(0));
      else begin
        pleft = blen;
        ph = pde_pkg::PH_ZERO;
      end
    end
  endfunction

  function automatic bit take_byte(logic [7:0] b);
    if (hold_f) return 1'b0;
    case (ph)
      pde_pkg::PH_IDLE: begin
        md = b[7:5];
        if (b[4:0] == 5'd0) begin
          vacc = 0;
          ph = pde_pkg::PH_ARG;
        end else begin
          begin_arg(32'(b[4:0]));
        end
        return 1'b1;
      end
      pde_pkg::PH_ARG, pde_pkg::PH_V2, pde_pkg::PH_V3: begin
        vacc = (vacc << 7) | 32'(b[6:0]);
        if (!b[7]) varint_complete(vacc);
        return 1'b1;
      end
      pde_pkg::PH_LOAD: begin
        pleft--;
        if (md == pde_pkg::MD_COPY) begin
          hold_b = b;
          hold_f = 1'b1;
        end else if (bidx < blen && bidx < DEPTH) begin
          block_mem[bidx] = b;
          bidx++;
          hold_b = b;
          hold_f = 1'b1;
        end else if (pleft == 0) begin
          void'(next_piece(0));
        end
        return 1'b1;
      end
      pde_pkg::PH_CUSTOM: begin
        pleft--;
        hold_b = b;
        hold_f = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_decoder();
    ph = pde_pkg::PH_IDLE;
    md = pde_pkg::MD_ZERO;
    vacc = 0; blen = 0; clen = 0; ccount = 0; rleft = 0; pleft = 0; bidx = 0;
    hold_b = 8'd0;
    hold_f = 1'b0;
  endfunction

  function automatic pde_pkg::res_t predict_result(logic [1:0] op, logic [7:0] b);
    pde_pkg::res_t r;
    r = '0;
    flt = pde_pkg::FLT_NONE;
    case (op)
      pde_pkg::OP_PUSH: r.accepted = take_byte(b);
      pde_pkg::OP_PULL: begin
        if (hold_f) begin
          r.out_valid = 1'b1;
          r.out_byte = hold_b;
          hold_f = 1'b0;
          hold_b = 8'd0;
          if (pleft == 0 && (ph == pde_pkg::PH_LOAD || ph == pde_pkg::PH_CUSTOM))
            r.piece_end = next_piece(ph == pde_pkg::PH_CUSTOM ? 1 : 0);
        end else if (ph == pde_pkg::PH_ZERO && pleft != 0) begin
          r.out_valid = 1'b1;
          pleft--;
          if (pleft == 0) r.piece_end = next_piece(0);
        end else if (ph == pde_pkg::PH_REPLAY && pleft != 0) begin
          r.out_valid = 1'b1;
          r.out_byte = (bidx < DEPTH) ? block_mem[bidx] : 8'd0;
          bidx++;
          pleft--;
          if (pleft == 0) r.piece_end = next_piece(0);
        end
      end
      pde_pkg::OP_RESTART: clear_decoder();
      default: ;
    endcase
    r.at_boundary = (ph == pde_pkg::PH_IDLE && !hold_f);
    r.fault = flt;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  // Queues one request together with its predicted result.
  task automatic send(logic [1:0] op, logic [7:0] b, output bit took);
    pde_pkg::req_t q;
    pde_pkg::res_t r;
    q.op = op;
    q.packed_byte = b;
    r = predict_result(op, b);
    pending_reqs = {pending_reqs, q};
    expected_results = {expected_results, r};
    took = r.accepted;
  endtask

  // Pushes one packed byte, pulling output while the decoder refuses input.
  task automatic push_byte(logic [7:0] b);
    bit took;
    for (int k = 0; k < 4000; k++) begin
      send(pde_pkg::OP_PUSH, b, took);
      if (took) return;
      send(pde_pkg::OP_PULL, 8'd0, took);
    end
  endtask

  task automatic push_varint(int unsigned v);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--)
      push_byte({i != 0, 7'((v >> (7 * i)) & 32'h7F)});
  endtask

  task automatic drain_output();
    bit took;
    for (int k = 0; k < 4000 && !(ph == pde_pkg::PH_IDLE && !hold_f); k++)
      send(pde_pkg::OP_PULL, 8'd0, took);
  endtask

  // Sends one whole instruction with random payload, then drains its output.
  task automatic send_instr(logic [2:0] mode, int unsigned arg, int unsigned rep,
                            int unsigned csz, int unsigned cnt, bit mid_pulls);
    bit took;
    int unsigned payload;
    if (arg != 0 && arg < 32) begin
      push_byte({mode, 5'(arg)});
    end else begin
      push_byte({mode, 5'd0});
      push_varint(arg);
    end
    payload = 0;
    case (mode)
      pde_pkg::MD_COPY: payload = arg;
      pde_pkg::MD_REPEAT: begin
        push_varint(rep);
        payload = arg;
      end
      pde_pkg::MD_ILV, pde_pkg::MD_ZILV: begin
        push_varint(csz);
        push_varint(cnt);
        if (!(csz == 0 && arg == 0))
          payload = (mode == pde_pkg::MD_ILV ? arg : 0) + csz * cnt;
      end
      default: ;
    endcase
    for (int unsigned i = 0; i < payload; i++) begin
      push_byte(8'($urandom));
      if (mid_pulls && $urandom_range(0, 3) == 0) send(pde_pkg::OP_PULL, 8'd0, took);
    end
    drain_output();
  endtask

  initial begin
    bit took;
    int unsigned sel;
    errors = 0;
    gen_done = 1'b0;
    for (int i = 0; i < DEPTH; i++) block_mem[i] = 8'd0;
    clear_decoder();

    // Directed part: each mode at its extremes and the special cases.
    send(pde_pkg::OP_PULL, 8'd0, took);                  // pull with nothing ready
    send_instr(pde_pkg::MD_ZERO, 31, 0, 0, 0, 1'b0);
    send_instr(pde_pkg::MD_ZERO, 0, 0, 0, 0, 1'b0);      // empty fill via varint
    send_instr(pde_pkg::MD_COPY, 3, 0, 0, 0, 1'b1);
    send_instr(pde_pkg::MD_REPEAT, 4, 2, 0, 0, 1'b0);
    send_instr(pde_pkg::MD_REPEAT, 0, 3, 0, 0, 1'b0);    // empty repeated block
    send_instr(pde_pkg::MD_ILV, 2, 3, 2, 0, 1'b0);
    send_instr(pde_pkg::MD_ILV, 0, 0, 7, 0, 1'b0);       // empty block and zero count
    send_instr(pde_pkg::MD_ZILV, 2, 2, 2, 0, 1'b0);
    send_instr(pde_pkg::MD_ZILV, 0, 3, 2, 0, 1'b0);      // no zero pieces
    send_instr(pde_pkg::MD_RSV5, 4, 0, 0, 0, 1'b0);      // undefined opcodes
    send_instr(pde_pkg::MD_RSV6, 32'hFFFF_FFFF, 0, 0, 0, 1'b0);
    send_instr(pde_pkg::MD_RSV7, 9, 0, 0, 0, 1'b0);
    send_instr(pde_pkg::MD_REPEAT, DEPTH + 1, 0, 0, 0, 1'b0);  // oversized block
    push_byte({pde_pkg::MD_COPY, 5'd4});                 // restart mid-instruction
    push_byte(8'hA5);
    send(pde_pkg::OP_RESTART, 8'd0, took);
    send(pde_pkg::OP_NOP, 8'hFF, took);                  // no-op request
    send_instr(pde_pkg::MD_REPEAT, 2, 1, 0, 0, 1'b0);

    // Random part: mostly well-formed instructions, some noise.
    while (pending_reqs.size() < 1050) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        send(pde_pkg::OP_RESTART, 8'($urandom), took);
      end else if (sel < 10) begin
        send(pde_pkg::OP_NOP, 8'($urandom), took);
        send(pde_pkg::OP_PULL, 8'($urandom), took);
      end else if (sel < 16) begin
        for (int k = 0; k < 3; k++) push_byte(8'($urandom));
        send(pde_pkg::OP_RESTART, 8'd0, took);
      end else begin
        send_instr(3'($urandom_range(0, 7)), $urandom_range(0, 40),
                   $urandom_range(0, 3), $urandom_range(0, 6),
                   $urandom_range(0, 3), 1'($urandom_range(0, 1)));
      end
    end
    total_reqs = pending_reqs.size();
    gen_done = 1'b1;
  end

  // ---------------------------------------------------------------- driver
  int send_idle_pct, recv_idle_pct;
  always_comb begin
    if (sent_reqs < total_reqs / 3) begin
      send_idle_pct = 30; recv_idle_pct = 61;
    end else if (sent_reqs < 2 * total_reqs / 3) begin
      send_idle_pct = 61; recv_idle_pct = 30;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    sent_reqs = 0;
  end

  always @(posedge clk) begin
    if (!rst_n || !gen_done) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_ch.data <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        sent_reqs <= sent_reqs + 1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    pde_pkg::res_t want;
    pde_pkg::res_t got;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
          if (got.out_valid !== want.out_valid)
            report_mismatch("out_valid", got.out_valid, want.out_valid);
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
          if (got.piece_end !== want.piece_end)
            report_mismatch("piece_end", got.piece_end, want.piece_end);
          if (got.at_boundary !== want.at_boundary)
            report_mismatch("at_boundary", got.at_boundary, want.at_boundary);
          if (got.fault !== want.fault)
            report_mismatch("fault", got.fault, want.fault);
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- end of run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    wait (gen_done);
    wait (pending_reqs.size() == 0 && !req_ch.valid && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
